### src/assert_macros.svh
// assertion macros shared by the phase resistance identifier
// depends on nothing; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PRI_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication
`define PRI_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### src/pri_pkg.sv
// widths, codes and the result word of the phase resistance identifier
// depends on nothing
`default_nettype none
package pri_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int COUNT_WIDTH  = 15;

	localparam int THR_W    = 15;
	localparam int WEIGHT_W = 16;
	localparam int STEP_W   = 10;
	localparam int GAIN_W   = 16;
	localparam int OFFSET_W = 16;
	localparam int DUTY_W   = 16;
	localparam int VOLT_W   = 21;
	localparam int SUM_W    = 30;
	localparam int RES_W    = 32;
	localparam int PHASE_W  = 2;

	localparam int CFG_W     = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
	localparam int CFG_IDX_W = 3;

	// shared multiplier operands, signed
	localparam int MUL_A_W = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;
	localparam int MUL_B_W = ((SAMPLE_WIDTH + 1 > VOLT_W) ? SAMPLE_WIDTH + 1 : VOLT_W) + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	localparam int FV_W       = SAMPLE_WIDTH + 2;
	localparam int CMP_W      = (SAMPLE_WIDTH - 1 > THR_W) ? SAMPLE_WIDTH - 1 : THR_W;
	localparam int DUTY_SUM_W = PROD_W - 15;
	localparam int VC_W       = VOLT_W + COUNT_WIDTH;
	localparam int NUM_W      = VC_W + 11;
	localparam int DIV_CNT_W  = $clog2(NUM_W + 1);

	localparam logic [15:0] ROUND_HALF = 16'd32768;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd5;

	localparam logic [THR_W-1:0]       RST_THRESHOLD = 15'd1000;
	localparam logic [WEIGHT_W-1:0]    RST_WEIGHT    = 16'd3277;
	localparam logic [STEP_W-1:0]      RST_STEP      = 10'd1;
	localparam logic [COUNT_WIDTH-1:0] RST_COUNT     = COUNT_WIDTH'(20000);
	localparam logic [GAIN_W-1:0]      RST_GAIN      = 16'd3520;
	localparam logic [OFFSET_W-1:0]    RST_OFFSET    = 16'd655;

	localparam logic [PHASE_W-1:0] PH_RAMP = 2'd0;
	localparam logic [PHASE_W-1:0] PH_AVG  = 2'd1;
	localparam logic [PHASE_W-1:0] PH_DONE = 2'd2;

	typedef struct packed {
		logic [DUTY_W-1:0]              duty_a;
		logic [PHASE_W-1:0]             phase;
		logic                           done_res;
		logic [RES_W-1:0]               resistance;
		logic signed [SAMPLE_WIDTH-1:0] filtered_current;
	} pri_word_t;

endpackage
`default_nettype wire

### src/pri_if.sv
// valid/ready channels for sample words and result words
// depends on pri_pkg
`default_nettype none
interface pri_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [pri_pkg::SAMPLE_WIDTH-1:0] current_sample;

	modport source (output valid, output current_sample, input ready);
	modport sink (input valid, input current_sample, output ready);
endinterface

interface pri_out_if;
	logic                                   valid;
	logic                                   ready;
	logic [pri_pkg::DUTY_W-1:0]              duty_a;
	logic [pri_pkg::PHASE_W-1:0]             phase;
	logic                                   done_res;
	logic [pri_pkg::RES_W-1:0]               resistance;
	logic signed [pri_pkg::SAMPLE_WIDTH-1:0] filtered_current;

	modport source (output valid, output duty_a, output phase, output done_res,
		output resistance, output filtered_current, input ready);
	modport sink (input valid, input duty_a, input phase, input done_res,
		input resistance, input filtered_current, output ready);
endinterface
`default_nettype wire

### src/pri_mul.sv
// shared signed multiplier with registered product
// depends on pri_pkg
`default_nettype none
module pri_mul (
	input  wire logic                               clk,
	input  wire logic signed [pri_pkg::MUL_A_W-1:0] a,
	input  wire logic signed [pri_pkg::MUL_B_W-1:0] b,
	output logic signed [pri_pkg::PROD_W-1:0]       prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule
`default_nettype wire

### src/pri_div.sv
// restoring divider, one quotient bit per cycle
// depends on pri_pkg
`default_nettype none
module pri_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [pri_pkg::NUM_W-1:0]    num,
	input  wire logic [pri_pkg::SUM_W-1:0]    den,
	output logic                              done,
	output logic [pri_pkg::NUM_W-1:0]         quo
);

	logic [pri_pkg::SUM_W-1:0]     rem_q;
	logic [pri_pkg::SUM_W-1:0]     den_q;
	logic [pri_pkg::NUM_W-1:0]     quo_q;
	logic [pri_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [pri_pkg::SUM_W:0]       rem_sh;
	logic                          fits;
	logic [pri_pkg::SUM_W:0]       rem_nx;

	always_comb begin
		rem_sh = {rem_q, quo_q[pri_pkg::NUM_W-1]};
		fits   = rem_sh >= {1'b0, den_q};
		rem_nx = fits ? rem_sh - {1'b0, den_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= pri_pkg::DIV_CNT_W'(pri_pkg::NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == pri_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= rem_nx[pri_pkg::SUM_W-1:0];
			quo_q <= {quo_q[pri_pkg::NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

### src/phase_resistance_identifier.sv
// phase resistance identifier by dc injection: filter, voltage ramp, averaging, divide
// depends on pri_pkg, pri_if, pri_mul, pri_div and assert_macros.svh
// states: ramp word with duty update FMUL, FUPD, DMUL, DUPD, OUT; ramp-ending and
// averaging word FMUL, FUPD, OUT; final word RMUL, RDIV, RWAIT until div_done, OUT,
// or OUT on a zero sum; done word OUT; samples taken only in IDLE, once OUT is left
// reset: async active low, registers to defaults, state to IDLE, phase ramping
`default_nettype none
`include "assert_macros.svh"
module phase_resistance_identifier (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	pri_in_if.sink                                samples,
	pri_out_if.source                             results,
	input  wire logic                             cfg_we,
	input  wire logic [pri_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [pri_pkg::CFG_W-1:0]        cfg_data
);

	localparam int SW = pri_pkg::SAMPLE_WIDTH;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_FMUL  = 9'b000000010,
		ST_FUPD  = 9'b000000100,
		ST_DMUL  = 9'b000001000,
		ST_DUPD  = 9'b000010000,
		ST_RMUL  = 9'b000100000,
		ST_RDIV  = 9'b001000000,
		ST_RWAIT = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	state_t state_q;

	logic [pri_pkg::THR_W-1:0]       thr_q;
	logic [pri_pkg::WEIGHT_W-1:0]    weight_q;
	logic [pri_pkg::STEP_W-1:0]      step_q;
	logic [pri_pkg::COUNT_WIDTH-1:0] count_q;
	logic [pri_pkg::GAIN_W-1:0]      gain_q;
	logic [pri_pkg::OFFSET_W-1:0]    offset_q;

	logic [pri_pkg::PHASE_W-1:0]     phase_q;
	logic signed [SW-1:0]            last_q;
	logic [pri_pkg::VOLT_W-1:0]      volt_q;
	logic [pri_pkg::COUNT_WIDTH-1:0] cnt_q;
	logic [pri_pkg::SUM_W-1:0]       sum_q;
	logic [pri_pkg::RES_W-1:0]       res_q;
	logic [pri_pkg::DUTY_W-1:0]      duty_q;

	logic signed [SW-1:0]            x_q;
	logic                            out_valid_q;
	pri_pkg::pri_word_t              out_q;

	logic signed [pri_pkg::MUL_A_W-1:0] mul_a;
	logic signed [pri_pkg::MUL_B_W-1:0] mul_b;
	logic signed [pri_pkg::PROD_W-1:0]  mul_prod;

	logic                             div_start;
	logic                             div_done;
	logic [pri_pkg::NUM_W-1:0]        div_num;
	logic [pri_pkg::NUM_W-1:0]        div_quo;

	logic                             in_acc;
	logic                             out_load;
	logic [pri_pkg::COUNT_WIDTH-1:0]  cnt_next;
	logic                             avg_more;
	logic signed [SW:0]               diff_c;
	logic signed [pri_pkg::PROD_W:0]  rnd_c;
	logic signed [pri_pkg::PROD_W:0]  q_c;
	logic signed [pri_pkg::FV_W-1:0]  fv_c;
	logic signed [SW-1:0]             fv_new;
	logic                             ramp_hit;
	logic [SW-1:0]                    abs_c;
	logic [pri_pkg::SUM_W:0]          sum_c;
	logic [pri_pkg::VOLT_W:0]         volt_c;
	logic [pri_pkg::DUTY_SUM_W-1:0]   duty_c;
	logic [pri_pkg::VC_W-1:0]         vc_c;
	logic [pri_pkg::RES_W-1:0]        res_c;

	pri_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (mul_prod)
	);

	pri_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (sum_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign samples.ready = (state_q == ST_IDLE);
	assign in_acc        = samples.valid && samples.ready;
	assign out_load      = (state_q == ST_OUT) && (!out_valid_q || results.ready);
	assign div_start     = (state_q == ST_RDIV);

	always_comb begin
		cnt_next = cnt_q + 1'b1;
		avg_more = cnt_next < count_q;
		diff_c   = $signed({x_q[SW-1], x_q}) - $signed({last_q[SW-1], last_q});

		priority if (state_q == ST_RMUL) begin
			mul_a = pri_pkg::MUL_A_W'(count_q);
			mul_b = pri_pkg::MUL_B_W'(volt_q);
		end else if (state_q == ST_DMUL) begin
			mul_a = pri_pkg::MUL_A_W'(gain_q);
			mul_b = pri_pkg::MUL_B_W'(volt_q);
		end else begin
			mul_a = pri_pkg::MUL_A_W'(weight_q);
			mul_b = {{(pri_pkg::MUL_B_W - SW - 1){diff_c[SW]}}, diff_c};
		end

		// round half up, floor toward minus infinity
		rnd_c = $signed({mul_prod[pri_pkg::PROD_W-1], mul_prod})
			+ $signed((pri_pkg::PROD_W + 1)'(pri_pkg::ROUND_HALF));
		q_c   = rnd_c >>> 16;
		fv_c  = $signed({{2{last_q[SW-1]}}, last_q}) + $signed(q_c[pri_pkg::FV_W-1:0]);

		if ((fv_c[pri_pkg::FV_W-1:SW-1] == '0) || (fv_c[pri_pkg::FV_W-1:SW-1] == '1)) begin
			fv_new = fv_c[SW-1:0];
		end else if (fv_c[pri_pkg::FV_W-1]) begin
			fv_new = {1'b1, {(SW - 1){1'b0}}};
		end else begin
			fv_new = {1'b0, {(SW - 1){1'b1}}};
		end

		ramp_hit = !fv_new[SW-1]
			&& (pri_pkg::CMP_W'(fv_new[SW-2:0]) > pri_pkg::CMP_W'(thr_q));
		abs_c    = fv_new[SW-1] ? SW'(-fv_new) : SW'(fv_new);
		sum_c    = {1'b0, sum_q} + (pri_pkg::SUM_W + 1)'(abs_c);
		volt_c   = {1'b0, volt_q} + (pri_pkg::VOLT_W + 1)'(step_q);
		duty_c   = pri_pkg::DUTY_SUM_W'(mul_prod[pri_pkg::PROD_W-1:16])
			+ pri_pkg::DUTY_SUM_W'(offset_q);

		// 1280 = 1024 + 256
		vc_c    = mul_prod[pri_pkg::VC_W-1:0];
		div_num = (pri_pkg::NUM_W'(vc_c) << 10) + (pri_pkg::NUM_W'(vc_c) << 8);
		res_c   = (|div_quo[pri_pkg::NUM_W-1:pri_pkg::RES_W]) ? '1
			: div_quo[pri_pkg::RES_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= pri_pkg::RST_THRESHOLD;
			weight_q    <= pri_pkg::RST_WEIGHT;
			step_q      <= pri_pkg::RST_STEP;
			count_q     <= pri_pkg::RST_COUNT;
			gain_q      <= pri_pkg::RST_GAIN;
			offset_q    <= pri_pkg::RST_OFFSET;
			state_q     <= ST_IDLE;
			phase_q     <= pri_pkg::PH_RAMP;
			last_q      <= '0;
			volt_q      <= '0;
			cnt_q       <= '0;
			sum_q       <= '0;
			res_q       <= '0;
			duty_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					pri_pkg::REG_THRESHOLD: thr_q    <= cfg_data[pri_pkg::THR_W-1:0];
					pri_pkg::REG_WEIGHT:    weight_q <= cfg_data[pri_pkg::WEIGHT_W-1:0];
					pri_pkg::REG_STEP:      step_q   <= cfg_data[pri_pkg::STEP_W-1:0];
					pri_pkg::REG_COUNT:     count_q  <= cfg_data[pri_pkg::COUNT_WIDTH-1:0];
					pri_pkg::REG_GAIN:      gain_q   <= cfg_data[pri_pkg::GAIN_W-1:0];
					pri_pkg::REG_OFFSET:    offset_q <= cfg_data[pri_pkg::OFFSET_W-1:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.valid && results.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (phase_q)
							pri_pkg::PH_RAMP: state_q <= ST_FMUL;
							pri_pkg::PH_AVG: begin
								cnt_q <= cnt_next;
								if (avg_more) begin
									state_q <= ST_FMUL;
								end else if (sum_q == '0) begin
									res_q   <= '1;
									duty_q  <= '0;
									phase_q <= pri_pkg::PH_DONE;
									state_q <= ST_OUT;
								end else begin
									state_q <= ST_RMUL;
								end
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_FMUL: state_q <= ST_FUPD;
				ST_FUPD: begin
					last_q <= fv_new;
					if (phase_q == pri_pkg::PH_RAMP) begin
						if (ramp_hit) begin
							phase_q <= pri_pkg::PH_AVG;
							state_q <= ST_OUT;
						end else begin
							volt_q  <= volt_c[pri_pkg::VOLT_W] ? '1
								: volt_c[pri_pkg::VOLT_W-1:0];
							state_q <= ST_DMUL;
						end
					end else begin
						sum_q   <= sum_c[pri_pkg::SUM_W] ? '1 : sum_c[pri_pkg::SUM_W-1:0];
						state_q <= ST_OUT;
					end
				end
				ST_DMUL: state_q <= ST_DUPD;
				ST_DUPD: begin
					duty_q  <= (|duty_c[pri_pkg::DUTY_SUM_W-1:pri_pkg::DUTY_W]) ? '1
						: duty_c[pri_pkg::DUTY_W-1:0];
					state_q <= ST_OUT;
				end
				ST_RMUL: state_q <= ST_RDIV;
				ST_RDIV: state_q <= ST_RWAIT;
				ST_RWAIT: begin
					if (div_done) begin
						res_q   <= res_c;
						duty_q  <= '0;
						phase_q <= pri_pkg::PH_DONE;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q <= samples.current_sample;
		end
		if (out_load) begin
			out_q.duty_a           <= duty_q;
			out_q.phase            <= phase_q;
			out_q.done_res         <= (phase_q == pri_pkg::PH_DONE);
			out_q.resistance       <= res_q;
			out_q.filtered_current <= last_q;
		end
	end

	assign results.valid            = out_valid_q;
	assign results.duty_a           = out_q.duty_a;
	assign results.phase            = out_q.phase;
	assign results.done_res         = out_q.done_res;
	assign results.resistance       = out_q.resistance;
	assign results.filtered_current = out_q.filtered_current;

	// done forces the duty to zero and is never left
	`PRI_ASSERT_IMP(a_done_duty_zero, clk, arst_n, phase_q == pri_pkg::PH_DONE, duty_q == '0)
	`PRI_ASSERT_NXT(a_done_sticks, clk, arst_n, phase_q == pri_pkg::PH_DONE, phase_q == pri_pkg::PH_DONE)
	// the divider only ever sees a nonzero sum
	`PRI_ASSERT_IMP(a_div_den_nonzero, clk, arst_n, div_start, sum_q != '0)

endmodule
`default_nettype wire

### sim/tb_top.sv
// self-checking bench for the phase resistance identifier: a directed table, then random
// ramp, averaging and done traffic, each word held to the table or an in-bench predictor
// depends on pri_pkg, pri_if and phase_resistance_identifier in src
`timescale 1ns / 100ps
module tb_top;
	import pri_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = NUM_W + 32;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam longint VOLT_TOP = (longint'(1) << VOLT_W) - 1;
	localparam longint SUM_TOP = (longint'(1) << SUM_W) - 1;
	localparam longint SAMPLE_TOP = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;
	typedef enum {FINISH_ZERO_SUM, FINISH_FULL_COUNT, FINISH_LOWERED_COUNT} finish_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   index;
		logic [CFG_W-1:0]       data;
		logic                   typed;
		pri_word_t              word;
	} stim_row_t;

	localparam pri_word_t RAMP_START = '{16'd655, PH_RAMP, 1'b0, 32'd0, 16'sd0};

	localparam stim_row_t DIRECTED [28] = '{
		'{ROW_SAMPLE, '0, 16'h0000, 1'b1, RAMP_START},
		'{ROW_SAMPLE, '0, 16'h0000, 1'b1, RAMP_START},
		'{ROW_WRITE, REG_THRESHOLD, 16'h7FFF, 1'b0, '0},
		'{ROW_SAMPLE, '0, 16'h7FFF, 1'b0, '0},
		'{ROW_SAMPLE, '0, 16'h8000, 1'b0, '0},
		'{ROW_SAMPLE, '0, 16'h7FFF, 1'b0, '0},
		'{ROW_WRITE, REG_WEIGHT, 16'hFFFF, 1'b0, '0},
		'{ROW_SAMPLE, '0, 16'h8000, 1'b0, '0},
		'{ROW_SAMPLE, '0, 16'h7FFF, 1'b0, '0},
		'{ROW_SAMPLE, '0, 16'h0000, 1'b0, '0},
		'{ROW_WRITE, REG_WEIGHT, 16'h0001, 1'b0, '0},
		'{ROW_SAMPLE, '0, 16'h8000, 1'b0, '0},
		'{ROW_WRITE, REG_STEP, 16'h03FF, 1'b0, '0},
		'{ROW_WRITE, REG_GAIN, 16'hFFFF, 1'b0, '0},
		'{ROW_SAMPLE, '0, 16'h0001, 1'b0, '0},
		'{ROW_WRITE, REG_OFFSET, 16'hFFFF, 1'b0, '0},
		'{ROW_SAMPLE, '0, 16'hFFFF, 1'b0, '0},
		'{ROW_WRITE, REG_GAIN, 16'h0000, 1'b0, '0},
		'{ROW_WRITE, REG_OFFSET, 16'h0000, 1'b0, '0},
		'{ROW_SAMPLE, '0, 16'h5555, 1'b0, '0},
		'{ROW_SAMPLE, '0, 16'hAAAA, 1'b0, '0},
		'{ROW_WRITE, REG_WEIGHT, 16'h0000, 1'b0, '0},
		'{ROW_SAMPLE, '0, 16'h7FFF, 1'b0, '0},
		'{ROW_WRITE, REG_UNUSED, 16'hFFFF, 1'b0, '0},
		'{ROW_WRITE, REG_COUNT, 16'hFFFF, 1'b0, '0},
		'{ROW_SAMPLE, '0, 16'h0000, 1'b0, '0},
		'{ROW_WRITE, REG_STEP, 16'h0000, 1'b0, '0},
		'{ROW_SAMPLE, '0, 16'h1234, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	pri_in_if samples_if();
	pri_out_if results_if();

	phase_resistance_identifier dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_if),
		.results(results_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// register copy
	logic [THR_W-1:0]       threshold_r;
	logic [WEIGHT_W-1:0]    weight_r;
	logic [STEP_W-1:0]      step_r;
	logic [COUNT_WIDTH-1:0] count_lim_r;
	logic [GAIN_W-1:0]      gain_r;
	logic [OFFSET_W-1:0]    offset_r;

	// identifier state copy
	logic [PHASE_W-1:0]             phase_s;
	logic signed [SAMPLE_WIDTH-1:0] filt_s;
	logic [VOLT_W-1:0]              volt_s;
	logic [COUNT_WIDTH-1:0]         counter_s;
	logic [SUM_W-1:0]               sum_s;
	logic [RES_W-1:0]               res_s;
	logic [DUTY_W-1:0]              duty_s;

	pri_word_t due_words[$];
	int err_count = 0;
	int accepted_words = 0;
	int send_idle = 24;
	int recv_idle = 80;
	int unsigned cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic signed [SAMPLE_WIDTH-1:0] pick_current();
		case ($urandom_range(7))
			0: return {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
			1: return {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
			2: return SAMPLE_WIDTH'(int'($urandom_range(64)) - 32);
			default: return SAMPLE_WIDTH'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_reg();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return CFG_W'(1);
			default: return CFG_W'($urandom);
		endcase
	endfunction

	task automatic filter_current(input logic signed [SAMPLE_WIDTH-1:0] x);
		longint q;
		longint v;
		q = (longint'(weight_r) * (longint'(x) - longint'(filt_s)) + 32768) >>> 16;
		v = longint'(filt_s) + q;
		if (v > SAMPLE_TOP)
			v = SAMPLE_TOP;
		if (v < -SAMPLE_TOP - 1)
			v = -SAMPLE_TOP - 1;
		filt_s = SAMPLE_WIDTH'(v);
	endtask

	task automatic step_identifier(input logic signed [SAMPLE_WIDTH-1:0] x,
			output pri_word_t w);
		longint total;
		logic [63:0] quot;
		case (phase_s)
			PH_RAMP: begin
				filter_current(x);
				if (longint'(filt_s) > longint'(threshold_r)) begin
					phase_s = PH_AVG;
				end else begin
					total = longint'(volt_s) + longint'(step_r);
					volt_s = (total > VOLT_TOP) ? '1 : VOLT_W'(total);
					total = ((longint'(gain_r) * longint'(volt_s)) >>> 16) + longint'(offset_r);
					duty_s = (total > 65535) ? '1 : DUTY_W'(total);
				end
			end
			PH_AVG: begin
				counter_s = counter_s + 1'b1;
				if (counter_s < count_lim_r) begin
					filter_current(x);
					total = (filt_s < 0) ? -longint'(filt_s) : longint'(filt_s);
					total = total + longint'(sum_s);
					sum_s = (total > SUM_TOP) ? '1 : SUM_W'(total);
				end else begin
					if (sum_s == 0) begin
						res_s = '1;
					end else begin
						quot = (64'd1280 * 64'(volt_s) * 64'(count_lim_r)) / 64'(sum_s);
						res_s = (quot > 64'hFFFF_FFFF) ? '1 : RES_W'(quot);
					end
					duty_s = '0;
					phase_s = PH_DONE;
				end
			end
			default: ;
		endcase
		w.duty_a = duty_s;
		w.phase = (phase_s > PH_DONE) ? PH_DONE : phase_s;
		w.done_res = (phase_s >= PH_DONE);
		w.resistance = res_s;
		w.filtered_current = filt_s;
	endtask

	task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] smp, input logic typed,
			input pri_word_t typed_word);
		pri_word_t w;
		cfg_we <= 1'b0;
		while ($urandom_range(99) < send_idle) begin
			samples_if.valid <= 1'b0;
			@(posedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.current_sample <= smp;
		do
			@(posedge clk);
		while (samples_if.ready !== 1'b1);
		step_identifier(smp, w);
		due_words.push_back(typed ? typed_word : w);
		accepted_words++;
		if (accepted_words == 330) begin
			send_idle = 80;
			recv_idle = 24;
		end else if (accepted_words == 660) begin
			send_idle = 0;
			recv_idle = 0;
		end
	endtask

	// waits for every due word before the register changes
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		samples_if.valid <= 1'b0;
		while (due_words.size() != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_THRESHOLD: threshold_r = data[THR_W-1:0];
			REG_WEIGHT:    weight_r = data[WEIGHT_W-1:0];
			REG_STEP:      step_r = data[STEP_W-1:0];
			REG_COUNT:     count_lim_r = data[COUNT_WIDTH-1:0];
			REG_GAIN:      gain_r = data[GAIN_W-1:0];
			REG_OFFSET:    offset_r = data[OFFSET_W-1:0];
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk) begin
		pri_word_t want;
		results_if.ready <= ($urandom_range(99) >= recv_idle);
		if (arst_n && results_if.valid && results_if.ready) begin
			if (due_words.size() == 0) begin
				$error("result word with none due");
				err_count++;
			end else begin
				want = due_words.pop_front();
				check_field("duty_a", want.duty_a, results_if.duty_a);
				check_field("phase", want.phase, results_if.phase);
				check_field("done_res", want.done_res, results_if.done_res);
				check_field("resistance", want.resistance, results_if.resistance);
				check_field("filtered_current", want.filtered_current,
					results_if.filtered_current);
			end
		end
	end

	initial begin
		finish_t ending;
		int ramp_words;
		int n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		samples_if.valid = 1'b0;
		samples_if.current_sample = '0;
		results_if.ready = 1'b0;
		threshold_r = RST_THRESHOLD;
		weight_r = RST_WEIGHT;
		step_r = RST_STEP;
		count_lim_r = RST_COUNT;
		gain_r = RST_GAIN;
		offset_r = RST_OFFSET;
		phase_s = PH_RAMP;
		filt_s = '0;
		volt_s = '0;
		counter_s = '0;
		sum_s = '0;
		res_s = '0;
		duty_s = '0;
		ramp_words = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(DIRECTED); i++) begin
			if (DIRECTED[i].kind == ROW_WRITE)
				write_reg(DIRECTED[i].index, DIRECTED[i].data);
			else
				send_sample(DIRECTED[i].data, DIRECTED[i].typed, DIRECTED[i].word);
		end

		// threshold out of reach so the ramp keeps running
		while (ramp_words < 800) begin
			write_reg(REG_THRESHOLD, {1'($urandom_range(1)), 15'h7FFF});
			if ($urandom_range(1))
				write_reg(REG_WEIGHT, pick_reg());
			write_reg(REG_STEP, ($urandom_range(7) != 0) ? {6'($urandom), 10'h3FF} : pick_reg());
			if ($urandom_range(1))
				write_reg(REG_GAIN, pick_reg());
			if ($urandom_range(1))
				write_reg(REG_OFFSET, pick_reg());
			if ($urandom_range(3) == 0)
				write_reg(REG_UNUSED, pick_reg());
			n = $urandom_range(20, 120);
			ramp_words += n;
			repeat (n) send_sample(pick_current(), 1'b0, '0);
		end

		ending = finish_t'($urandom_range(2));
		write_reg(REG_THRESHOLD, $urandom_range(1) ? '0 : CFG_W'($urandom_range(1, 2000)));
		write_reg(REG_WEIGHT, CFG_W'($urandom_range(8192, 65535)));
		case (ending)
			FINISH_ZERO_SUM:   write_reg(REG_COUNT, CFG_W'($urandom_range(1)));
			FINISH_FULL_COUNT: write_reg(REG_COUNT, ($urandom_range(3) == 0) ? CFG_W'(2) :
				CFG_W'($urandom_range(3, 300)));
			default:           write_reg(REG_COUNT, '1);
		endcase
		while (phase_s == PH_RAMP)
			send_sample(SAMPLE_WIDTH'($urandom_range(4096, 32767)), 1'b0, '0);

		if (ending == FINISH_LOWERED_COUNT) begin
			repeat ($urandom_range(50, 300)) send_sample(pick_current(), 1'b0, '0);
			write_reg(REG_COUNT, CFG_W'($urandom_range(0, counter_s)));
		end
		while (phase_s == PH_AVG)
			send_sample(pick_current(), 1'b0, '0);

		// done holds whatever the registers say
		write_reg(REG_STEP, pick_reg());
		write_reg(REG_GAIN, pick_reg());
		write_reg(REG_COUNT, pick_reg());
		repeat (40) send_sample(pick_current(), 1'b0, '0);

		samples_if.valid <= 1'b0;
		while (due_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
